// ----- rtl/core/cfd_pkg.sv -----
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types and constants of the checksummed frame deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam logic [7:0] PREAMBLE_BYTE = 8'h00;
  localparam logic [7:0] START_BYTE    = 8'hFF;

  // Parser phase. Codes six and seven are never entered.
  typedef enum logic [2:0] {
    PH_HUNT0  = 3'd0,
    PH_HUNTFF = 3'd1,
    PH_LEN    = 3'd2,
    PH_LCS    = 3'd3,
    PH_DATA   = 3'd4,
    PH_DCS    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  value;
    logic [7:0]  position;
  } result_t;

endpackage

// ----- rtl/core/cfd_in_stage.sv -----
// ----------------------------------------------------------------------------
// cfd_in_stage
// Input register: captures one received byte per cycle while it is not stalled.
// ----------------------------------------------------------------------------
module cfd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  // The register can take a new item when it is empty or drains this cycle.
  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load ? 1'b1 : (advance_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ----- rtl/core/cfd_parser.sv -----
// ----------------------------------------------------------------------------
// cfd_parser
// Frame state machine: hunts for the start sequence, checks the length,
// streams payload bytes and checks the data checksum.
// ----------------------------------------------------------------------------
module cfd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       byte_i,
  output logic             res_valid_o,
  output cfd_pkg::result_t res_o
);

  cfd_pkg::phase_e phase_q, phase_d;
  logic [7:0]      bytes_left_q, bytes_left_d;
  logic [7:0]      frame_length_q, frame_length_d;
  logic [7:0]      running_sum_q, running_sum_d;
  logic [7:0]      byte_index_q, byte_index_d;
  logic [7:0]      sum_next;
  logic [7:0]      check_want;

  assign sum_next   = running_sum_q + byte_i;
  assign check_want = 8'h00 - frame_length_q;

  always_comb begin
    phase_d         = phase_q;
    bytes_left_d    = bytes_left_q;
    frame_length_d  = frame_length_q;
    running_sum_d   = running_sum_q;
    byte_index_d    = byte_index_q;
    res_valid_o     = 1'b0;
    res_o.kind      = cfd_pkg::KIND_DATA;
    res_o.value     = byte_i;
    res_o.position  = byte_index_q;
    case (phase_q)
      cfd_pkg::PH_HUNTFF: begin
        if (byte_i == cfd_pkg::START_BYTE) begin
          phase_d = cfd_pkg::PH_LEN;
        end else if (byte_i != cfd_pkg::PREAMBLE_BYTE) begin
          phase_d = cfd_pkg::PH_HUNT0;
        end
      end
      cfd_pkg::PH_LEN: begin
        frame_length_d = byte_i;
        phase_d        = cfd_pkg::PH_LCS;
      end
      cfd_pkg::PH_LCS: begin
        // A zero length frame is an acknowledge and is dropped here.
        if (byte_i == check_want && frame_length_q != 8'd0) begin
          phase_d       = cfd_pkg::PH_DATA;
          bytes_left_d  = frame_length_q;
          running_sum_d = 8'd0;
          byte_index_d  = 8'd0;
        end else begin
          phase_d = cfd_pkg::PH_HUNT0;
        end
      end
      cfd_pkg::PH_DATA: begin
        res_valid_o   = 1'b1;
        running_sum_d = sum_next;
        byte_index_d  = byte_index_q + 8'd1;
        if (bytes_left_q <= 8'd1) begin
          bytes_left_d = 8'd0;
          phase_d      = cfd_pkg::PH_DCS;
        end else begin
          bytes_left_d = bytes_left_q - 8'd1;
        end
      end
      cfd_pkg::PH_DCS: begin
        res_valid_o    = 1'b1;
        running_sum_d  = sum_next;
        res_o.kind     = (sum_next == 8'd0) ? cfd_pkg::KIND_GOOD : cfd_pkg::KIND_BAD;
        res_o.value    = frame_length_q;
        res_o.position = 8'd0;
        phase_d        = cfd_pkg::PH_HUNT0;
      end
      default: begin
        phase_d = (byte_i == cfd_pkg::PREAMBLE_BYTE) ? cfd_pkg::PH_HUNTFF
                                                     : cfd_pkg::PH_HUNT0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= cfd_pkg::PH_HUNT0;
      bytes_left_q   <= 8'd0;
      frame_length_q <= 8'd0;
      running_sum_q  <= 8'd0;
      byte_index_q   <= 8'd0;
    end else if (fire_i) begin
      phase_q        <= phase_d;
      bytes_left_q   <= bytes_left_d;
      frame_length_q <= frame_length_d;
      running_sum_q  <= running_sum_d;
      byte_index_q   <= byte_index_d;
    end
  end

  // In the payload phase the bytes seen plus the bytes to come make the length.
  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == cfd_pkg::PH_DATA |-> 8'(byte_index_q + bytes_left_q) == frame_length_q)
    else $error("payload counters disagree with frame length");

  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == cfd_pkg::PH_DATA |-> bytes_left_q != 8'd0)
    else $error("payload phase with no bytes left");

  a_dcs_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && phase_q == cfd_pkg::PH_DCS |=> phase_q == cfd_pkg::PH_HUNT0)
    else $error("checksum byte did not end the frame");

endmodule

// ----- rtl/core/cfd_out_stage.sv -----
// ----------------------------------------------------------------------------
// cfd_out_stage
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module cfd_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  input  cfd_pkg::result_t res_i,
  output logic             advance_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cfd_pkg::result_t res_o
);

  logic             valid_q, valid_d;
  cfd_pkg::result_t res_q;

  // The stage moves on when it is empty or its item is taken this cycle.
  assign advance_o = !valid_q || !out_stall_i;
  assign valid_d   = advance_o ? res_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/core/checksummed_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// checksummed_frame_deframer
// Finds 00..00 FF LEN LCS payload DCS frames in a byte stream and reports
// payload bytes and a good or bad status for every frame with a good, nonzero length.
// ----------------------------------------------------------------------------
// Usage: received bytes enter on in_valid_i / rx_byte_i and are taken at an
// edge where in_valid_i is high and in_stall_o is low. Results leave on
// out_valid_o with kind_o, value_o and position_o, and are taken at an edge
// where out_valid_o is high and out_stall_i is low. Each payload byte comes
// out as one item with its index; the data checksum byte produces one status
// item carrying the frame length. Preamble, length and check bytes produce
// nothing, and frames with a bad length check or zero length vanish silently.
// A result passes through two register stages from port to port, and the block
// takes one byte every cycle while the receiver does not stall: an input
// register feeds the frame state machine, whose result lands in an output
// register.
// When the receiver stalls, the output register holds its item and the input
// register holds one more byte; only when both are full does in_stall_o rise.
// Reset returns the parser to hunting for the first 0x00 and empties both
// registers.
// ----------------------------------------------------------------------------
module checksummed_frame_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] value_o,
  output logic [7:0] position_o
);

  logic             advance;
  logic             stage_valid;
  logic [7:0]       stage_byte;
  logic             res_valid;
  cfd_pkg::result_t res;
  cfd_pkg::result_t out_res;

  cfd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .byte_o     (stage_byte)
  );

  // The parser state moves only when the buffered byte is handed on.
  cfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (stage_valid && advance),
    .byte_i      (stage_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cfd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid && stage_valid),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign kind_o     = out_res.kind;
  assign value_o    = out_res.value;
  assign position_o = out_res.position;

  // The input side only backs up when a result is held by a stalled receiver.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

endmodule
